// File: hw/rtl/tridiagonal_gaussian_sampler_core_macros.svh
// Assertion macros shared by the sampler RTL.
`ifndef TRIDIAGONAL_GAUSSIAN_SAMPLER_CORE_MACROS_SVH
`define TRIDIAGONAL_GAUSSIAN_SAMPLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TGS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tgs_pkg.sv
// Shared constants, types and fixed-point helpers for the sampler.
`default_nettype none

package tgs_pkg;

    localparam int MAX_LEN   = 64;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PREC_W    = 31;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int CFG_IDX_W = 2;
    // a + 2b stays below 2^(PREC_W+2); one more bit for sign
    localparam int TGT_W     = PREC_W + 3;
    localparam int RAD_W     = 2 * ((TGT_W - 1 + FRAC_BITS + 1) / 2);
    localparam int ROOT_W    = RAD_W / 2;
    localparam int DVD_W     = DATA_W + FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ADD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd3;

    localparam logic [ROOT_W-1:0] ONE_ROOT = ROOT_W'(1) << FRAC_BITS;

    typedef logic signed [DATA_W-1:0] sdata_t;

    typedef struct packed {
        logic                start;
        logic signed [DATA_W-1:0] num;
        logic [ROOT_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    function automatic sdata_t sat_data(input logic signed [63:0] v);
        sdata_t r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < 64'shFFFF_FFFF_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // product scaled back, truncated toward zero
    function automatic sdata_t mulq(input logic signed [63:0] prod);
        logic signed [63:0] adj;
        logic signed [63:0] sh;
        adj = prod + (prod[63] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0);
        sh  = adj >>> FRAC_BITS;
        return sat_data(sh);
    endfunction

    function automatic sdata_t sat_sub(input sdata_t p, input sdata_t q);
        logic signed [DATA_W:0] w;
        w = (DATA_W+1)'(p) - (DATA_W+1)'(q);
        return sat_data(64'(w));
    endfunction

    function automatic sdata_t sat_add(input sdata_t p, input sdata_t q);
        logic signed [DATA_W:0] w;
        w = (DATA_W+1)'(p) + (DATA_W+1)'(q);
        return sat_data(64'(w));
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tgs_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none

module tgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tgs_div.sv
// Restoring divider, one quotient bit per cycle: sat((num << FRAC) / den).
`default_nettype none

module tgs_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tgs_pkg::div_req_t req,
    output tgs_pkg::div_rsp_t      rsp
);

    localparam int DW = tgs_pkg::DVD_W;
    localparam int RW = tgs_pkg::ROOT_W;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] dq_reg, dq_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] den_reg, den_next;

    logic [tgs_pkg::DATA_W-1:0] mag;
    logic [RW:0]   sh;
    logic [RW:0]   diff;
    logic          ge;

    always_comb
    begin
        mag  = req.num[tgs_pkg::DATA_W-1] ? (~req.num + 1'b1) : req.num;
        sh   = {rem_reg, dq_reg[DW-1]};
        diff = sh - {1'b0, den_reg};
        ge   = (sh >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            neg_next  = req.num[tgs_pkg::DATA_W-1];
            dq_next   = {mag, {tgs_pkg::FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[RW-1:0] : sh[RW-1:0];
            dq_next  = {dq_reg[DW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // sign and saturation of the finished magnitude
    always_comb
    begin
        rsp.done = done_reg;
        if (!neg_reg)
        begin
            if (|dq_reg[DW-1:tgs_pkg::DATA_W-1])
                rsp.quot = 32'sh7FFF_FFFF;
            else
                rsp.quot = $signed(dq_reg[tgs_pkg::DATA_W-1:0]);
        end
        else
        begin
            if ((|dq_reg[DW-1:tgs_pkg::DATA_W]) ||
                (dq_reg[tgs_pkg::DATA_W-1] && (|dq_reg[tgs_pkg::DATA_W-2:0])))
                rsp.quot = 32'sh8000_0000;
            else
                rsp.quot = $signed(~dq_reg[tgs_pkg::DATA_W-1:0] + 1'b1);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tgs_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none

module tgs_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tgs_pkg::sqrt_req_t req,
    output tgs_pkg::sqrt_rsp_t      rsp
);

    localparam int AW = tgs_pkg::RAD_W;
    localparam int RW = tgs_pkg::ROOT_W;
    localparam int CW = $clog2(RW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] rad_reg, rad_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RW:0]   rem_reg, rem_next;

    logic [RW+2:0] sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    always_comb
    begin
        sh    = {rem_reg, rad_reg[AW-1 -: 2]};
        trial = (RW+3)'({root_reg, 2'b01});
        diff  = sh - trial;
        ge    = (sh >= trial);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(RW);
            rad_next  = req.rad;
            root_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[AW-3:0], 2'b00};
            rem_next  = ge ? diff[RW:0] : sh[RW:0];
            root_next = {root_reg[RW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tridiagonal_gaussian_sampler_core.sv
// Top level: load memories, Cholesky sequencer over RAMs, result output.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | sink      | in_valid/in_stall  | rhs_value, noise_value, last_element
//  out     | source    | out_valid/out_stall| sample_value, sample_index, last_sample,
//          |           |                    | not_positive_definite
//  cfg     | sink      | cfg_we             | cfg_index, cfg_data
//
// Loading accepts one input transaction per cycle while in_stall is low. The item marked
// last starts a solve of n elements: a forward pass and a back substitution, with up to
// four quotients per element from the shared one-bit-per-cycle divider and a root step.
// Each result is then read, registered and held on the output until out_stall is low.
// in_stall stays high from the last item until the final result is taken.
// Reset (rst_n, asynchronous) clears control state; memory contents stay undefined.
`default_nettype none
`include "tridiagonal_gaussian_sampler_core_macros.svh"

module tridiagonal_gaussian_sampler_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input element channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [tgs_pkg::DATA_W-1:0] rhs_value,
    input  wire logic signed [tgs_pkg::DATA_W-1:0] noise_value,
    input  wire logic                            last_element,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [tgs_pkg::DATA_W-1:0]    sample_value,
    output logic [tgs_pkg::ADDR_W-1:0]           sample_index,
    output logic                                 last_sample,
    output logic                                 not_positive_definite,
    // configuration writes
    input  wire logic                            cfg_we,
    input  wire logic [tgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tgs_pkg::PREC_W-1:0]      cfg_data
);

    localparam int DW = tgs_pkg::DATA_W;
    localparam int AW = tgs_pkg::ADDR_W;
    localparam int CW = tgs_pkg::CNT_W;
    localparam int PW = tgs_pkg::PREC_W;
    localparam int TW = tgs_pkg::TGT_W;
    localparam int RW = tgs_pkg::ROOT_W;

    // forward pass (F_*), back substitution (B_*), result drain (O_*)
    typedef enum logic [19:0] {
        ST_IDLE        = 20'h00001,
        ST_F_LV_START  = 20'h00002,
        ST_F_LV_WAIT   = 20'h00004,
        ST_F_SQ        = 20'h00008,
        ST_F_TGT       = 20'h00010,
        ST_F_ROOT      = 20'h00020,
        ST_F_ROOT_WAIT = 20'h00040,
        ST_F_MLF       = 20'h00080,
        ST_F_NUM       = 20'h00100,
        ST_F_DIV_WAIT  = 20'h00200,
        ST_B_READ      = 20'h00400,
        ST_B_MX        = 20'h00800,
        ST_B_XDIV      = 20'h01000,
        ST_B_XWAIT     = 20'h02000,
        ST_B_MS        = 20'h04000,
        ST_B_SDIV      = 20'h08000,
        ST_B_SWAIT     = 20'h10000,
        ST_O_READ      = 20'h20000,
        ST_O_LOAD      = 20'h40000,
        ST_O_WAIT      = 20'h80000
    } state_t;

    // configuration
    logic [PW-1:0] level_reg, level_next;
    logic [PW-1:0] coupling_reg, coupling_next;
    logic          last_add_reg, last_add_next;
    logic [CW-1:0] length_reg, length_next;

    // sequencer
    state_t        state_reg, state_next;
    logic [CW-1:0] load_count_reg, load_count_next;
    logic [AW-1:0] i_reg, i_next;
    logic [CW-1:0] n_reg, n_next;
    logic          bad_reg, bad_next;

    // datapath registers
    tgs_pkg::sdata_t     lv_reg, lv_next;
    tgs_pkg::sdata_t     fwd_prev_reg, fwd_prev_next;
    logic [RW-1:0]       piv_prev_reg, piv_prev_next;
    logic [RW-1:0]       d_reg, d_next;
    logic signed [TW-1:0] tgt_reg, tgt_next;
    logic signed [63:0]  prod_reg, prod_next;
    tgs_pkg::sdata_t     x_next_reg, x_next_next;
    tgs_pkg::sdata_t     s_next_reg, s_next_next;

    // output stage
    logic            out_valid_reg, out_valid_next;
    tgs_pkg::sdata_t sample_value_reg, sample_value_next;
    logic [AW-1:0]   sample_index_reg, sample_index_next;
    logic            last_sample_reg, last_sample_next;
    logic            npd_reg, npd_next;

    // memory ports
    logic          load_we;
    logic          piv_we, sub_we, fwd_we, res_we;
    logic [DW-1:0] rhs_rd, noise_rd, piv_rd, sub_rd, fwd_rd, res_rd;
    logic [DW-1:0] sub_wdata, fwd_wdata, res_wdata;

    // shared arithmetic units
    tgs_pkg::div_req_t  div_req;
    tgs_pkg::div_rsp_t  div_rsp;
    tgs_pkg::sqrt_req_t sqrt_req;
    tgs_pkg::sqrt_rsp_t sqrt_rsp;

    logic            in_acc;
    logic [AW-1:0]   nm1;
    logic            at_end;
    logic [TW-1:0]   diag_u, last_diag_u, target_u;
    tgs_pkg::sdata_t mq;
    tgs_pkg::sdata_t lvb;
    tgs_pkg::sdata_t mul_a, mul_b;
    logic [CW-1:0]   len_clamped;

    assign in_acc = in_valid && !in_stall;
    assign nm1    = AW'(n_reg - CW'(1));
    assign at_end = (i_reg == nm1);

    always_comb
    begin
        diag_u      = TW'(level_reg) + (TW'(coupling_reg) << 1);
        last_diag_u = last_add_reg ? (TW'(level_reg) + TW'(coupling_reg))
                                   : TW'(coupling_reg);
        target_u    = at_end ? last_diag_u : diag_u;
        mq          = tgs_pkg::mulq(prod_reg);
        // last row has no subdiagonal entry
        lvb         = at_end ? '0 : $signed(sub_rd);
        if (length_reg < CW'(3))
            len_clamped = CW'(3);
        else if (length_reg > CW'(tgs_pkg::MAX_LEN))
            len_clamped = CW'(tgs_pkg::MAX_LEN);
        else
            len_clamped = length_reg;
    end

    // operand selection for the single multiplier
    always_comb
    begin
        case (state_reg)
            ST_F_SQ:
            begin
                mul_a = lv_reg;
                mul_b = lv_reg;
            end
            ST_F_MLF:
            begin
                mul_a = lv_reg;
                mul_b = fwd_prev_reg;
            end
            ST_B_MX:
            begin
                mul_a = lvb;
                mul_b = x_next_reg;
            end
            ST_B_MS:
            begin
                mul_a = lvb;
                mul_b = s_next_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        level_next    = level_reg;
        coupling_next = coupling_reg;
        last_add_next = last_add_reg;
        length_next   = length_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tgs_pkg::CFG_LEVEL:    level_next    = cfg_data;
                tgs_pkg::CFG_COUPLING: coupling_next = cfg_data;
                tgs_pkg::CFG_LAST_ADD: last_add_next = cfg_data[0];
                tgs_pkg::CFG_LENGTH:   length_next   = cfg_data[CW-1:0];
                default:               level_next    = level_reg;
            endcase
        end
    end

    // main sequencer
    always_comb
    begin
        state_next        = state_reg;
        load_count_next   = load_count_reg;
        i_next            = i_reg;
        n_next            = n_reg;
        bad_next          = bad_reg;
        lv_next           = lv_reg;
        fwd_prev_next     = fwd_prev_reg;
        piv_prev_next     = piv_prev_reg;
        d_next            = d_reg;
        tgt_next          = tgt_reg;
        prod_next         = prod_reg;
        x_next_next       = x_next_reg;
        s_next_next       = s_next_reg;
        out_valid_next    = out_valid_reg;
        sample_value_next = sample_value_reg;
        sample_index_next = sample_index_reg;
        last_sample_next  = last_sample_reg;
        npd_next          = npd_reg;

        load_we   = 1'b0;
        piv_we    = 1'b0;
        sub_we    = 1'b0;
        fwd_we    = 1'b0;
        res_we    = 1'b0;
        sub_wdata = div_rsp.quot;
        fwd_wdata = div_rsp.quot;
        res_wdata = tgs_pkg::sat_add(x_next_reg, div_rsp.quot);

        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = d_reg;
        sqrt_req.start = 1'b0;
        sqrt_req.rad   = tgs_pkg::RAD_W'({tgt_reg[TW-2:0], {tgs_pkg::FRAC_BITS{1'b0}}});

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    // elements past the store depth are dropped
                    if (!load_count_reg[CW-1])
                    begin
                        load_we         = 1'b1;
                        load_count_next = load_count_reg + 1'b1;
                    end
                    if (last_element)
                    begin
                        load_count_next = '0;
                        n_next          = len_clamped;
                        i_next          = '0;
                        lv_next         = '0;
                        fwd_prev_next   = '0;
                        bad_next        = 1'b0;
                        state_next      = ST_F_SQ;
                    end
                end
            end
            ST_F_LV_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = -$signed(DW'(coupling_reg));
                div_req.den   = piv_prev_reg;
                state_next    = ST_F_LV_WAIT;
            end
            ST_F_LV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    sub_we     = 1'b1;
                    lv_next    = div_rsp.quot;
                    state_next = ST_F_SQ;
                end
            end
            ST_F_SQ:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_F_TGT;
            end
            ST_F_TGT:
            begin
                tgt_next   = $signed(target_u) - TW'(mq);
                state_next = ST_F_ROOT;
            end
            ST_F_ROOT:
            begin
                if (tgt_reg[TW-1] || (tgt_reg == '0))
                begin
                    // pivot not positive: flag it, continue with 1.0
                    bad_next   = 1'b1;
                    d_next     = tgs_pkg::ONE_ROOT;
                    state_next = ST_F_MLF;
                end
                else
                begin
                    sqrt_req.start = 1'b1;
                    state_next     = ST_F_ROOT_WAIT;
                end
            end
            ST_F_ROOT_WAIT:
            begin
                if (sqrt_rsp.done)
                begin
                    d_next     = sqrt_rsp.root;
                    state_next = ST_F_MLF;
                end
            end
            ST_F_MLF:
            begin
                piv_we     = 1'b1;
                prod_next  = mul_a * mul_b;
                state_next = ST_F_NUM;
            end
            ST_F_NUM:
            begin
                div_req.start = 1'b1;
                div_req.num   = tgs_pkg::sat_sub($signed(rhs_rd), mq);
                div_req.den   = d_reg;
                state_next    = ST_F_DIV_WAIT;
            end
            ST_F_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    fwd_we        = 1'b1;
                    fwd_prev_next = div_rsp.quot;
                    piv_prev_next = d_reg;
                    if (at_end)
                    begin
                        x_next_next = '0;
                        s_next_next = '0;
                        state_next  = ST_B_READ;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_F_LV_START;
                    end
                end
            end
            ST_B_READ:
            begin
                state_next = ST_B_MX;
            end
            ST_B_MX:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_B_XDIV;
            end
            ST_B_XDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = tgs_pkg::sat_sub($signed(fwd_rd), mq);
                div_req.den   = piv_rd[RW-1:0];
                state_next    = ST_B_XWAIT;
            end
            ST_B_XWAIT:
            begin
                if (div_rsp.done)
                begin
                    x_next_next = div_rsp.quot;
                    state_next  = ST_B_MS;
                end
            end
            ST_B_MS:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_B_SDIV;
            end
            ST_B_SDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = tgs_pkg::sat_sub($signed(noise_rd), mq);
                div_req.den   = piv_rd[RW-1:0];
                state_next    = ST_B_SWAIT;
            end
            ST_B_SWAIT:
            begin
                if (div_rsp.done)
                begin
                    res_we      = 1'b1;
                    s_next_next = div_rsp.quot;
                    if (i_reg == '0)
                    begin
                        state_next = ST_O_READ;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = ST_B_READ;
                    end
                end
            end
            ST_O_READ:
            begin
                state_next = ST_O_LOAD;
            end
            ST_O_LOAD:
            begin
                out_valid_next    = 1'b1;
                sample_value_next = $signed(res_rd);
                sample_index_next = i_reg;
                last_sample_next  = at_end;
                npd_next          = bad_reg;
                state_next        = ST_O_WAIT;
            end
            ST_O_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_O_READ;
                    end
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= PW'(65536);
            coupling_reg   <= PW'(65536);
            last_add_reg   <= 1'b1;
            length_reg     <= CW'(tgs_pkg::MAX_LEN);
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            i_reg          <= '0;
            n_reg          <= CW'(3);
            bad_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            level_reg      <= level_next;
            coupling_reg   <= coupling_next;
            last_add_reg   <= last_add_next;
            length_reg     <= length_next;
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            n_reg          <= n_next;
            bad_reg        <= bad_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lv_reg           <= lv_next;
        fwd_prev_reg     <= fwd_prev_next;
        piv_prev_reg     <= piv_prev_next;
        d_reg            <= d_next;
        tgt_reg          <= tgt_next;
        prod_reg         <= prod_next;
        x_next_reg       <= x_next_next;
        s_next_reg       <= s_next_next;
        sample_value_reg <= sample_value_next;
        sample_index_reg <= sample_index_next;
        last_sample_reg  <= last_sample_next;
        npd_reg          <= npd_next;
    end

    assign in_stall              = (state_reg != ST_IDLE);
    assign out_valid             = out_valid_reg;
    assign sample_value          = sample_value_reg;
    assign sample_index          = sample_index_reg;
    assign last_sample           = last_sample_reg;
    assign not_positive_definite = npd_reg;

    // element stores, all read at the current element index
    tgs_ram #(.WIDTH(DW), .DEPTH(tgs_pkg::MAX_LEN)) u_rhs_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (rhs_value),
        .raddr (i_reg),
        .rdata (rhs_rd)
    );

    tgs_ram #(.WIDTH(DW), .DEPTH(tgs_pkg::MAX_LEN)) u_noise_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (noise_value),
        .raddr (i_reg),
        .rdata (noise_rd)
    );

    tgs_ram #(.WIDTH(DW), .DEPTH(tgs_pkg::MAX_LEN)) u_pivot_ram (
        .clk   (clk),
        .we    (piv_we),
        .waddr (i_reg),
        .wdata (DW'(d_reg)),
        .raddr (i_reg),
        .rdata (piv_rd)
    );

    tgs_ram #(.WIDTH(DW), .DEPTH(tgs_pkg::MAX_LEN)) u_subdiag_ram (
        .clk   (clk),
        .we    (sub_we),
        .waddr (i_reg - 1'b1),
        .wdata (sub_wdata),
        .raddr (i_reg),
        .rdata (sub_rd)
    );

    tgs_ram #(.WIDTH(DW), .DEPTH(tgs_pkg::MAX_LEN)) u_forward_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (i_reg),
        .wdata (fwd_wdata),
        .raddr (i_reg),
        .rdata (fwd_rd)
    );

    // r = x + s per element, written back to front, drained front to back
    tgs_ram #(.WIDTH(DW), .DEPTH(tgs_pkg::MAX_LEN)) u_result_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (i_reg),
        .wdata (res_wdata),
        .raddr (i_reg),
        .rdata (res_rd)
    );

    tgs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tgs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    `TGS_ASSERT_NOW(a_out_only_in_hold, out_valid_reg, state_reg == ST_O_WAIT, "result valid outside hold state")
    `TGS_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, (state_reg == ST_F_LV_WAIT) || (state_reg == ST_F_DIV_WAIT) || (state_reg == ST_B_XWAIT) || (state_reg == ST_B_SWAIT), "quotient arrived outside a wait state")
    `TGS_ASSERT_NOW(a_load_bound, 1'b1, load_count_reg <= CW'(tgs_pkg::MAX_LEN), "load count beyond store depth")
    `TGS_ASSERT_NEXT(a_last_to_idle, out_valid_reg && !out_stall && last_sample_reg, state_reg == ST_IDLE, "no return to idle after last result")

endmodule

`default_nettype wire
